// ----- src/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the HDBn line decoder RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition holds at every clock edge outside reset.
`define ASSERT_ALWAYS(name, cond) \
   name: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error("assertion failed: %m");

// Check that a consequent holds in the cycle after an antecedent.
`define ASSERT_NEXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed: %m");

`endif

// ----- src/hdbn_pkg.sv -----
// ----------------------------------------------------------------------------
// HDBn decoder package
// Transaction types and fixed constants of the HDBn line decoder.
// ----------------------------------------------------------------------------
package hdbn_pkg;

   localparam int HdbOrderWidth = 3;
   localparam logic [HdbOrderWidth-1:0] HdbOrderMin   = 3'd2;
   localparam logic [HdbOrderWidth-1:0] HdbOrderReset = 3'd3;

   typedef struct packed {
      logic p_pulse;
      logic n_pulse;
      logic end_of_message;
   } hdbn_req_type;

   typedef struct packed {
      logic data_bit;
      logic last_bit;
   } hdbn_rsp_type;

   typedef struct packed {
      logic load;
      logic last;
   } hdbn_load_ctl_type;

endpackage

// ----- src/hdbn_core.sv -----
// ----------------------------------------------------------------------------
// HDBn decode core
// Polarity tracking, violation clearing and the symbol delay line.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hdbn_core
   import hdbn_pkg::*;
#(
   parameter int MAX_ORDER = 7,
   localparam int Depth = MAX_ORDER + 1,
   localparam int CntWidth = $clog2(Depth + 1)
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_write_enable,
   input  logic [HdbOrderWidth-1:0] csr_write_data,
   input  logic                     fire,
   input  hdbn_req_type             item,
   output hdbn_load_ctl_type        load_ctl,
   output logic [Depth-1:0]         load_bits,
   output logic [CntWidth-1:0]      load_count
);

   logic [HdbOrderWidth-1:0] order_ff;
   logic [Depth-1:0]         line_ff, line_in;
   logic [CntWidth-1:0]      fill_ff, fill_in;
   logic                     pol_ff, pol_in;

   logic [CntWidth-1:0] order;
   logic [CntWidth-1:0] fill_push;
   logic [CntWidth-1:0] pop_count;
   logic [Depth-1:0]    line_new;
   logic                pulse;
   logic                violation;
   logic                mark;

   always_comb begin
      // clamp the programmed order into the supported range
      if (int'(order_ff) < int'(HdbOrderMin)) begin
         order = CntWidth'(HdbOrderMin);
      end else if (int'(order_ff) > MAX_ORDER) begin
         order = CntWidth'(MAX_ORDER);
      end else begin
         order = CntWidth'(order_ff);
      end

      pulse     = item.p_pulse ^ item.n_pulse;
      violation = pulse && (item.p_pulse == pol_ff);
      mark      = pulse && !violation;

      // clear the newest held symbols on a violation, then push this one
      line_new = line_ff;
      for (int j = 0; j < Depth; j++) begin
         if (violation && (j < int'(fill_ff)) && ((j + int'(order)) >= int'(fill_ff))) begin
            line_new[j] = 1'b0;
         end
         if (j == int'(fill_ff)) begin
            line_new[j] = mark;
         end
      end

      fill_push = fill_ff + CntWidth'(1);

      if (item.end_of_message) begin
         pop_count = fill_push;
      end else if (fill_push > order) begin
         pop_count = fill_push - order;
      end else begin
         pop_count = '0;
      end

      for (int j = 0; j < Depth; j++) begin
         load_bits[j] = (j < int'(pop_count)) && line_new[j];
      end
      load_count    = pop_count;
      load_ctl.load = fire;
      load_ctl.last = item.end_of_message;

      // advance state; end of message returns to the reset state
      line_in = line_ff;
      fill_in = fill_ff;
      pol_in  = pol_ff;
      if (fire) begin
         if (item.end_of_message) begin
            line_in = '0;
            fill_in = '0;
            pol_in  = 1'b0;
         end else begin
            line_in = line_new >> pop_count;
            fill_in = fill_push - pop_count;
            pol_in  = mark ? item.p_pulse : pol_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         order_ff <= HdbOrderReset;
         line_ff  <= '0;
         fill_ff  <= '0;
         pol_ff   <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            order_ff <= csr_write_data;
         end
         line_ff <= line_in;
         fill_ff <= fill_in;
         pol_ff  <= pol_in;
      end
   end

   `ASSERT_ALWAYS(a_fill_bounded, int'(fill_ff) <= MAX_ORDER)
   `ASSERT_NEXT(a_eom_clears, fire && item.end_of_message, (fill_ff == '0) && !pol_ff)

endmodule

// ----- src/hdbn_out_queue.sv -----
// ----------------------------------------------------------------------------
// HDBn output queue
// Holds the decoded bits of one transaction and releases one per cycle while the receiver does not stall.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hdbn_out_queue
   import hdbn_pkg::*;
#(
   parameter int MAX_ORDER = 7,
   localparam int Depth = MAX_ORDER + 1,
   localparam int CntWidth = $clog2(Depth + 1)
) (
   input  logic                clock,
   input  logic                reset,
   input  hdbn_load_ctl_type   load_ctl,
   input  logic [Depth-1:0]    load_bits,
   input  logic [CntWidth-1:0] load_count,
   output logic                load_ready,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output hdbn_rsp_type        rsp_data
);

   logic [Depth-1:0]    bits_ff, bits_in;
   logic [CntWidth-1:0] count_ff, count_in;
   logic                last_ff, last_in;
   logic                pop;

   always_comb begin
      rsp_valid         = (count_ff != '0);
      pop               = rsp_valid && !rsp_stall;
      load_ready        = (count_ff == '0) || ((count_ff == CntWidth'(1)) && !rsp_stall);
      rsp_data.data_bit = bits_ff[0];
      rsp_data.last_bit = last_ff && (count_ff == CntWidth'(1));

      bits_in  = bits_ff;
      count_in = count_ff;
      last_in  = last_ff;
      if (load_ctl.load) begin
         bits_in  = load_bits;
         count_in = load_count;
         last_in  = load_ctl.last && (load_count != '0);
      end else if (pop) begin
         bits_in  = bits_ff >> 1;
         count_in = count_ff - CntWidth'(1);
         if (count_ff == CntWidth'(1)) begin
            last_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         last_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         last_ff  <= last_in;
      end
      bits_ff <= bits_in;
   end

   `ASSERT_ALWAYS(a_count_bounded, int'(count_ff) <= Depth)
   `ASSERT_ALWAYS(a_last_needs_data, !last_ff || (count_ff != '0))
   `ASSERT_ALWAYS(a_load_when_ready, !load_ctl.load || load_ready)

endmodule

// ----- src/hdbn_line_decoder.sv -----
// ----------------------------------------------------------------------------
// HDBn line decoder
// Decodes bipolar HDBn line symbols back to binary data.
// ----------------------------------------------------------------------------
// Each request transaction carries one received symbol as its positive and
// negative rail bits; a pulse repeating the polarity of the previous pulse is
// a violation and clears itself and the hdb_order symbols before it. Decoded
// bits leave hdb_order symbols after they enter, one response transaction
// each. In steady state, while the receiver does not stall, the block takes
// one symbol per cycle and returns one bit per cycle; each symbol passes the
// input register, then the output queue. A symbol marked end_of_message
// flushes every held bit, the last one carrying last_bit, and lowering
// hdb_order mid-message releases the excess held bits at once; the request
// side stalls while such a burst drains, one bit per unstalled cycle.
// Write hdb_order only while the block is idle. There is no clearing pass
// after reset.
`include "assert_macros.svh"

module hdbn_line_decoder
   import hdbn_pkg::*;
#(
   parameter int MAX_ORDER = 7
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  hdbn_req_type             req_data,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output hdbn_rsp_type             rsp_data,
   input  logic                     csr_write_enable,
   input  logic [HdbOrderWidth-1:0] csr_write_data
);

   localparam int Depth = MAX_ORDER + 1;
   localparam int CntWidth = $clog2(Depth + 1);

   // input register: one symbol waiting to be decoded
   hdbn_req_type item_ff;
   logic         item_valid_ff, item_valid_in;

   logic                load_ready;
   logic                fire;
   logic                req_accept;
   hdbn_load_ctl_type   load_ctl;
   logic [Depth-1:0]    load_bits;
   logic [CntWidth-1:0] load_count;

   // decode the held symbol once the queue can take its bits
   assign fire       = item_valid_ff && load_ready;
   // stall only while a symbol is held and cannot advance
   assign req_stall  = item_valid_ff && !load_ready;
   assign req_accept = req_valid && !req_stall;

   always_comb begin
      item_valid_in = item_valid_ff;
      if (req_accept) begin
         item_valid_in = 1'b1;
      end else if (fire) begin
         item_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else begin
         item_valid_ff <= item_valid_in;
      end
      if (req_accept) begin
         item_ff <= req_data;
      end
   end

   hdbn_core #(
      .MAX_ORDER(MAX_ORDER)
   ) u_core (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .fire             (fire),
      .item             (item_ff),
      .load_ctl         (load_ctl),
      .load_bits        (load_bits),
      .load_count       (load_count)
   );

   hdbn_out_queue #(
      .MAX_ORDER(MAX_ORDER)
   ) u_out_queue (
      .clock      (clock),
      .reset      (reset),
      .load_ctl   (load_ctl),
      .load_bits  (load_bits),
      .load_count (load_count),
      .load_ready (load_ready),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

   // an accepted symbol is always held in the next cycle
   `ASSERT_NEXT(a_accept_holds, req_accept, item_valid_ff)

endmodule

// ----- tb/sv/hdbn_line_decoder_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HDBn line decoder testbench
// Drives line symbols, with bursts of idle cycles and random response stalls,
// through the decoder. A bit-accurate predictor inside a small scoreboard
// works out the decoded bits for every accepted symbol. Each response
// transaction is then checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module hdbn_line_decoder_test
   import hdbn_pkg::*;
();

   localparam int MaxOrder    = 7;
   localparam int DrainCycles = 8;
   localparam int DrainLimit  = 2000;
   localparam int CycleLimit  = 400000;
   localparam int RandomItems = 480;

   // Receiver stall patterns, rotated at random.
   typedef enum logic [1:0] {RxFlowing, RxRandom, RxPeriodic, RxBursty} rx_mode_type;

   // Shapes of a generated message.
   typedef enum logic [1:0] {MsgEncoded, MsgCorrupt, MsgNoise} msg_style_type;

   // -------------------------------------------------------------------------
   // Scoreboard: predicts decoded bits and checks responses against them.
   // -------------------------------------------------------------------------
   class hdbn_bit_scoreboard;
      logic [HdbOrderWidth-1:0] order_reg;
      bit           held_bits[MaxOrder+1];
      bit           last_positive;
      int           held_count;
      hdbn_rsp_type expected_bits[$];
      int           error_count;

      function new();
         order_reg   = HdbOrderReset;
         error_count = 0;
         clear_line();
      endfunction

      function void clear_line();
         foreach (held_bits[i]) held_bits[i] = 1'b0;
         held_count    = 0;
         last_positive = 1'b0;
      endfunction

      function int pending();
         return expected_bits.size();
      endfunction

      task report_mismatch(input string what);
         error_count++;
         $display("[%0t] mismatch: %s", $time, what);
      endtask

      // Advance the decoder state by one symbol and queue the bits it releases.
      function void note_symbol(input hdbn_req_type sym);
         int           eff;
         int           clr;
         bit           mark;
         hdbn_rsp_type out_bit;
         eff = int'(order_reg);
         if (eff < int'(HdbOrderMin)) eff = int'(HdbOrderMin);
         if (eff > MaxOrder) eff = MaxOrder;
         mark = 1'b0;
         if (sym.p_pulse != sym.n_pulse) begin
            if (sym.p_pulse == last_positive) begin
               // violation: zero the newest held symbols, polarity kept
               clr = (held_count < eff) ? held_count : eff;
               for (int i = 0; i < clr; i++) held_bits[held_count - 1 - i] = 1'b0;
            end else begin
               last_positive = sym.p_pulse;
               mark = 1'b1;
            end
         end
         if (held_count < MaxOrder + 1) begin
            held_bits[held_count] = mark;
            held_count++;
         end
         if (sym.end_of_message) begin
            for (int i = 0; i < held_count; i++) begin
               out_bit.data_bit = held_bits[i];
               out_bit.last_bit = (i == held_count - 1);
               expected_bits.push_back(out_bit);
            end
            clear_line();
         end else begin
            while (held_count > eff) begin
               out_bit.data_bit = held_bits[0];
               out_bit.last_bit = 1'b0;
               expected_bits.push_back(out_bit);
               for (int i = 1; i < held_count; i++) held_bits[i-1] = held_bits[i];
               held_count--;
            end
         end
      endfunction

      task check_bit(input hdbn_rsp_type got);
         hdbn_rsp_type want;
         if (expected_bits.size() == 0) begin
            report_mismatch($sformatf("unexpected bit data %0b last %0b",
                                      got.data_bit, got.last_bit));
         end else begin
            want = expected_bits.pop_front();
            if (got.data_bit !== want.data_bit)
               report_mismatch($sformatf("data_bit %0b, wanted %0b",
                                         got.data_bit, want.data_bit));
            if (got.last_bit !== want.last_bit)
               report_mismatch($sformatf("last_bit %0b, wanted %0b",
                                         got.last_bit, want.last_bit));
         end
      endtask
   endclass

   // -------------------------------------------------------------------------
   // Clock, reset and block inputs, all known from time zero.
   // -------------------------------------------------------------------------
   logic                     clock            = 1'b0;
   logic                     reset            = 1'b1;
   logic                     req_valid        = 1'b0;
   logic                     req_stall;
   hdbn_req_type             req_data         = '0;
   logic                     rsp_valid;
   logic                     rsp_stall        = 1'b0;
   hdbn_rsp_type             rsp_data;
   logic                     csr_write_enable = 1'b0;
   logic [HdbOrderWidth-1:0] csr_write_data   = '0;

   hdbn_bit_scoreboard sb = new();

   hdbn_req_type msg_q[$];
   int           burst_left  = 0;
   int           items_sent  = 0;
   int           cycle_count = 0;

   always #2 clock = ~clock;

   hdbn_line_decoder #(
      .MAX_ORDER(MaxOrder)
   ) i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   // -------------------------------------------------------------------------
   // Monitor: sample both handshakes at the rising edge. Note the request
   // first so that a prediction always exists before its response is seen.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) sb.note_symbol(req_data);
         if (rsp_valid && !rsp_stall) sb.check_bit(rsp_data);
      end
   end

   // -------------------------------------------------------------------------
   // Receiver: stall on a pattern of its own. Rotate between a free-flowing
   // stretch, random stalls, a fixed period and long stall runs so that gaps
   // land on every position of a flush burst.
   // -------------------------------------------------------------------------
   rx_mode_type rx_mode  = RxFlowing;
   int          rx_left  = 0;
   int          rx_run   = 0;
   int          rx_phase = 0;

   always @(negedge clock) begin
      logic next_stall;
      if (rx_left == 0) begin
         rx_mode = rx_mode_type'($urandom_range(3));
         rx_left = $urandom_range(20, 200);
      end
      rx_left--;
      rx_phase++;
      next_stall = 1'b0;
      case (rx_mode)
         RxFlowing:  next_stall = 1'b0;
         RxRandom:   next_stall = ($urandom_range(99) < 35);
         RxPeriodic: next_stall = (rx_phase % 5 >= 3);
         RxBursty: begin
            if (rx_run > 0) begin
               rx_run--;
               next_stall = 1'b1;
            end else if ($urandom_range(9) == 0) begin
               rx_run = $urandom_range(2, 12);
               next_stall = 1'b1;
            end
         end
      endcase
      rsp_stall <= next_stall;
   end

   // -------------------------------------------------------------------------
   // Cycle limit: end the run if the traffic never completes.
   // -------------------------------------------------------------------------
   initial begin
      while (cycle_count < CycleLimit) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("[hdbn_line_decoder] ERROR");
      $finish;
   end

   // -------------------------------------------------------------------------
   // Sender tasks
   // -------------------------------------------------------------------------
   function automatic hdbn_req_type make_symbol(input bit p, input bit n, input bit eom);
      hdbn_req_type sym;
      sym.p_pulse        = p;
      sym.n_pulse        = n;
      sym.end_of_message = eom;
      return sym;
   endfunction

   // Present one symbol and hold it until the block takes it.
   task send_symbol(input hdbn_req_type sym);
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= sym;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // Drop valid for a number of cycles.
   task pause_sender(input int cycles);
      repeat (cycles) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
   endtask

   // Send in bursts of random length, now and then a long one; insert a random
   // gap before most bursts, and none before the rest.
   task send_item(input hdbn_req_type sym);
      if (burst_left == 0) begin
         burst_left = ($urandom_range(7) == 0) ? $urandom_range(40, 90)
                                                : $urandom_range(1, 12);
         pause_sender(($urandom_range(3) == 0) ? 0 : $urandom_range(1, 6));
      end
      burst_left--;
      send_symbol(sym);
      items_sent++;
   endtask

   // Hold the sender until every predicted bit has come back, then let the
   // pipeline settle, since a filling delay line releases nothing.
   task wait_drained();
      int waited;
      waited = 0;
      pause_sender(1);
      while (sb.pending() != 0 && waited < DrainLimit) begin
         @(posedge clock);
         waited++;
      end
      if (sb.pending() != 0) begin
         sb.report_mismatch($sformatf("%0d bits never arrived", sb.pending()));
         sb.expected_bits.delete();
      end
      repeat (DrainCycles) @(posedge clock);
   endtask

   // Write the order register while the block is idle.
   task write_order(input logic [HdbOrderWidth-1:0] value);
      wait_drained();
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      sb.order_reg = value;
   endtask

   // Build a message into msg_q. Encoded messages follow the HDBn rule:
   // alternate marks, and replace each run of order+1 zeros by an optional
   // bipolar mark and a violation, depending on the marks since the last one.
   task build_message(input int len, input int eff, input msg_style_type style,
                      input bit close);
      hdbn_req_type sym;
      int           zero_run;
      int           marks;
      int           ones_pct;
      int           start;
      bit           pol;
      zero_run = 0;
      marks    = 0;
      pol      = 1'b0;
      ones_pct = $urandom_range(5, 90);
      msg_q.delete();
      for (int i = 0; i < len; i++) begin
         if (style == MsgNoise) begin
            sym = make_symbol(1'($urandom_range(1)), 1'($urandom_range(1)), 1'b0);
            msg_q.push_back(sym);
         end else if ($urandom_range(99) < ones_pct) begin
            pol = !pol;
            marks++;
            zero_run = 0;
            msg_q.push_back(make_symbol(pol, !pol, 1'b0));
         end else begin
            zero_run++;
            msg_q.push_back(make_symbol(1'b0, 1'b0, 1'b0));
            if (zero_run == eff + 1) begin
               start = msg_q.size() - eff - 1;
               if (marks % 2 == 0) begin
                  pol = !pol;
                  msg_q[start] = make_symbol(pol, !pol, 1'b0);
               end
               msg_q[msg_q.size()-1] = make_symbol(pol, !pol, 1'b0);
               zero_run = 0;
               marks    = 0;
            end
         end
      end
      // Break a well-formed message by scrambling a few rails.
      if (style == MsgCorrupt) begin
         repeat ($urandom_range(1, 3)) begin
            start = $urandom_range(msg_q.size() - 1);
            msg_q[start].p_pulse = 1'($urandom_range(1));
            msg_q[start].n_pulse = 1'($urandom_range(1));
         end
      end
      msg_q[msg_q.size()-1].end_of_message = close;
   endtask

   // -------------------------------------------------------------------------
   // Main sequence
   // -------------------------------------------------------------------------
   initial begin
      int                       order_seq[8];
      int                       tmp;
      int                       pick;
      int                       eff;
      int                       n_msgs;
      int                       len;
      int                       style_roll;
      msg_style_type            style;
      logic [HdbOrderWidth-1:0] order_val;

      // Hold reset, then release it on a falling edge.
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part, order at its reset value.
      send_item(make_symbol(1'b0, 1'b1, 1'b0)); // violation before any symbol held
      send_item(make_symbol(1'b1, 1'b0, 1'b0)); // positive mark
      send_item(make_symbol(1'b1, 1'b1, 1'b0)); // both rails set, no pulse
      send_item(make_symbol(1'b0, 1'b0, 1'b0)); // space
      send_item(make_symbol(1'b0, 1'b1, 1'b0)); // negative mark
      send_item(make_symbol(1'b0, 1'b1, 1'b0)); // violation clears held symbols
      send_item(make_symbol(1'b1, 1'b0, 1'b1)); // end of message flushes the line
      send_item(make_symbol(1'b1, 1'b1, 1'b1)); // one-symbol message

      // Fill a deep line, then lower the order mid-message: excess bits leave
      // together on the next symbol.
      write_order(3'd7);
      send_item(make_symbol(1'b1, 1'b0, 1'b0));
      send_item(make_symbol(1'b0, 1'b0, 1'b0));
      send_item(make_symbol(1'b0, 1'b1, 1'b0));
      send_item(make_symbol(1'b0, 1'b0, 1'b0));
      send_item(make_symbol(1'b1, 1'b0, 1'b0));
      send_item(make_symbol(1'b0, 1'b0, 1'b0));
      write_order(HdbOrderMin);
      send_item(make_symbol(1'b0, 1'b1, 1'b0));
      send_item(make_symbol(1'b0, 1'b1, 1'b0));
      send_item(make_symbol(1'b1, 1'b0, 1'b0));
      send_item(make_symbol(1'b1, 1'b0, 1'b0));
      send_item(make_symbol(1'b0, 1'b1, 1'b1));

      // Order below the legal range acts as the minimum.
      write_order(3'd0);
      send_item(make_symbol(1'b0, 1'b0, 1'b0));
      send_item(make_symbol(1'b1, 1'b0, 1'b0));
      send_item(make_symbol(1'b0, 1'b1, 1'b1));

      // Random part: visit every order value once in shuffled order, then
      // pick at random. Each phase sends a few messages and may leave the
      // last one open so the next phase changes the order mid-message.
      foreach (order_seq[i]) order_seq[i] = i;
      for (int i = 7; i > 0; i--) begin
         pick = $urandom_range(i);
         tmp = order_seq[i];
         order_seq[i] = order_seq[pick];
         order_seq[pick] = tmp;
      end

      tmp = items_sent + RandomItems;
      for (int phase = 0; items_sent < tmp; phase++) begin
         order_val = (phase < 8) ? HdbOrderWidth'(order_seq[phase])
                                 : HdbOrderWidth'($urandom_range(7));
         write_order(order_val);
         eff = int'(order_val);
         if (eff < int'(HdbOrderMin)) eff = int'(HdbOrderMin);
         n_msgs = $urandom_range(2, 5);
         for (int m = 0; m < n_msgs; m++) begin
            len = ($urandom_range(9) == 0) ? $urandom_range(40, 70) : $urandom_range(1, 20);
            style_roll = $urandom_range(99);
            if (style_roll < 70)      style = MsgEncoded;
            else if (style_roll < 85) style = MsgCorrupt;
            else                      style = MsgNoise;
            build_message(len, eff, style,
                          !(m == n_msgs - 1 && $urandom_range(3) == 0));
            foreach (msg_q[i]) send_item(msg_q[i]);
         end
      end

      // Close out: hold the sender, wait for the last bits, then report.
      wait_drained();
      if (sb.error_count == 0) begin
         $display("[hdbn_line_decoder] OK");
      end else begin
         $display("[hdbn_line_decoder] ERROR");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
+incdir+src
src/hdbn_pkg.sv
src/hdbn_core.sv
src/hdbn_out_queue.sv
src/hdbn_line_decoder.sv
tb/sv/hdbn_line_decoder_test.sv
